[src/modular_exponentiation_core_macros.svh]
// ----------------------------------------------------------------------------
// modular exponentiation core assertion macros
// shared clocked assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MEX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mex_pkg.sv]
// ----------------------------------------------------------------------------
// mex_pkg
// register map, register word type and shared constants of the core
// ----------------------------------------------------------------------------
package mex_pkg;

  // register word and bus widths
  localparam int REG_W  = 32;
  localparam int ADDR_W = 4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_PRIVATE_EXP = 2'd1;
  localparam logic [1:0] REG_PEER_EXP    = 2'd2;

  // reset values
  localparam logic [REG_W-1:0] MODULUS_RST = 32'd2;
  localparam logic [REG_W-1:0] EXP_RST     = 32'd1;

  // register contents handed to the datapath, upper bits zero above the word
  typedef struct packed {
    logic [REG_W-1:0] modulus;
    logic [REG_W-1:0] private_exponent;
    logic [REG_W-1:0] peer_exponent;
  } mex_cfg_t;

endpackage

[src/modular_exponentiation_core.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// right-to-left square-and-multiply exponentiation over one shared
// bit-serial modular multiplier; W = min(MOD_BITS, 32)
// the base is reduced first; then each exponent bit up to the top set bit is
//   tested, multiplied into the accumulator when set, and the base squared;
//   the multiplier works one bit per cycle; busy is high throughout, so one
//   word is in flight; a modulus below 2 answers zero in the next cycle
// results are strobed for one cycle and cannot be stalled
// synchronous active-low reset: idle, modulus 2, both exponents 1
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core #(
  parameter int MOD_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [31:0]                in_message_value,
  // result channel
  output logic                       out_valid,
  output logic [31:0]                out_result_value,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mex_pkg::ADDR_W-1:0] paddr,
  input  logic [mex_pkg::REG_W-1:0]  pwdata,
  output logic [mex_pkg::REG_W-1:0]  prdata,
  output logic                       pready
);

  import mex_pkg::*;

  localparam int W = (MOD_BITS < REG_W) ? MOD_BITS : REG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_TEST,
    ST_MULACC,
    ST_SQUARE
  } state_t;

  state_t       state_r;
  mex_cfg_t     cfg;
  logic [W-1:0] modulus;
  logic [W-1:0] base_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] exp_r;
  logic         go_r;
  logic         out_valid_r;
  logic [31:0]  out_value_r;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_prod;
  logic         accept;

  // register file
  mex_regs #(.W(W)) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign modulus = cfg.modulus[W-1:0];

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      ST_REDUCE: begin
        mul_a = W'(1);
        mul_b = base_r;
      end
      ST_MULACC: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
      ST_SQUARE: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mex_mulmod #(.W(W)) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // sequencer: reduce the base, then scan exponent bits from the lsb
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (modulus < W'(2)) begin
              out_valid_r <= 1'b1;
              out_value_r <= '0;
            end else begin
              base_r  <= in_message_value[W-1:0];
              exp_r   <= in_mode ? cfg.peer_exponent[W-1:0]
                                 : cfg.private_exponent[W-1:0];
              acc_r   <= W'(1);
              go_r    <= 1'b1;
              state_r <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            base_r  <= mul_prod;
            state_r <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (exp_r == '0) begin
            out_valid_r <= 1'b1;
            out_value_r <= 32'(acc_r);
            state_r     <= ST_IDLE;
          end else if (exp_r[0]) begin
            go_r    <= 1'b1;
            state_r <= ST_MULACC;
          end else begin
            go_r    <= 1'b1;
            state_r <= ST_SQUARE;
          end
        end
        ST_MULACC: begin
          if (mul_done) begin
            acc_r   <= mul_prod;
            go_r    <= 1'b1;
            state_r <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mul_done) begin
            base_r  <= mul_prod;
            exp_r   <= exp_r >> 1;
            state_r <= ST_TEST;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

  // checks
  `MEX_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid,
    "accepted word neither started nor answered")
  `MEX_ASSERT_NOW(a_result_idle, out_valid, !busy,
    "result strobed while the sequencer is busy")
  `MEX_ASSERT_NOW(a_result_reduced, out_valid && (modulus >= W'(2)),
    out_result_value < 32'(modulus), "result not reduced below the modulus")
  `MEX_ASSERT_NOW(a_mul_done_owned, mul_done,
    state_r == ST_REDUCE || state_r == ST_MULACC || state_r == ST_SQUARE,
    "multiplier finished with no operation pending")

endmodule

[src/mex_mulmod.sv]
// ----------------------------------------------------------------------------
// mex_mulmod
// bit-serial modular multiplier: one multiplier bit per cycle, msb first,
// double-and-reduce then conditional add-and-reduce
// ----------------------------------------------------------------------------
module mex_mulmod #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  r_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [W:0]    dbl;
  logic [W:0]    sum;

  // one step: r = 2r mod m, then r = r + a mod m when the bit is set
  always_comb begin
    dbl = {1'b0, r_r} + {1'b0, r_r};
    if (dbl >= {1'b0, m}) begin
      dbl = dbl - {1'b0, m};
    end
    sum = {1'b0, dbl[W-1:0]} + (b[cnt_r] ? {1'b0, a} : '0);
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
  end

  // step counter and partial remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      r_r <= '0;
    end else if (run_r) begin
      r_r <= sum[W-1:0];
    end
  end

  assign done = done_r;
  assign prod = r_r;

endmodule

[src/mex_regs.sv]
// ----------------------------------------------------------------------------
// mex_regs
// apb register file: modulus, private exponent and peer exponent
// ----------------------------------------------------------------------------
module mex_regs #(
  parameter int W = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mex_pkg::ADDR_W-1:0] paddr,
  input  logic [mex_pkg::REG_W-1:0]  pwdata,
  output logic [mex_pkg::REG_W-1:0]  prdata,
  output logic                      pready,
  output mex_pkg::mex_cfg_t         cfg
);

  import mex_pkg::*;

  logic [W-1:0] modulus_r;
  logic [W-1:0] priv_exp_r;
  logic [W-1:0] peer_exp_r;
  logic         wr_en;
  logic [1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes, word masked to the datapath width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MODULUS_RST[W-1:0];
      priv_exp_r <= EXP_RST[W-1:0];
      peer_exp_r <= EXP_RST[W-1:0];
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODULUS:     modulus_r  <= pwdata[W-1:0];
        REG_PRIVATE_EXP: priv_exp_r <= pwdata[W-1:0];
        REG_PEER_EXP:    peer_exp_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_MODULUS:     prdata = REG_W'(modulus_r);
      REG_PRIVATE_EXP: prdata = REG_W'(priv_exp_r);
      REG_PEER_EXP:    prdata = REG_W'(peer_exp_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.modulus          = REG_W'(modulus_r);
  assign cfg.private_exponent = REG_W'(priv_exp_r);
  assign cfg.peer_exponent    = REG_W'(peer_exp_r);

endmodule
